// ===== hw/rtl/ksne_pkg.sv =====
// ksne_pkg: shared types and constants of the keypad scanner and number entry block
`timescale 1ns / 1ps

package ksne_pkg;

    // scanner phases
    typedef enum logic [1:0] {
        PH_WAIT_PRESS   = 2'd0,
        PH_SCAN         = 2'd1,
        PH_WAIT_RELEASE = 2'd2
    } t_scan_phase;

    // what the scanner hands to the number builder for one tick
    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        logic [7:0] key_code;
    } t_key_rec;

    localparam int unsigned KEY_REC_W = $bits(t_key_rec);

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEYMAP_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEYMAP_HIGH = 2'd1;

    // default map 1 2 3 B / 4 5 6 E / 7 8 9 = / S 0 < >
    localparam logic [63:0] KEYMAP_LOW_RST  = 64'h4536_3534_4233_3231;
    localparam logic [63:0] KEYMAP_HIGH_RST = 64'h3E3C_3053_3D39_3837;

    // column and row codes
    localparam logic [3:0] COLS_RELEASED = 4'hF;
    localparam logic [3:0] DRIVE_ALL     = 4'h0;
    localparam logic [3:0] DRIVE_ROW0    = 4'hE;
    localparam logic [1:0] ROW_LAST      = 2'd3;

    // digit codes
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [3:0] DECIMAL_BASE = 4'd10;

endpackage

// ===== hw/rtl/keypad_scan_number_entry.sv =====
// keypad_scan_number_entry: 4x4 key matrix scanner with decimal number entry
`timescale 1ns / 1ps
//
// Input queue: push a column sample when full is low; one sample per scan tick.
// Result queue: while empty is low the oldest result sits on the o_ ports,
// pop takes it. Each sample gives exactly one result: the row nibble to drive
// for the next tick, a decoded key if any, and the number being entered.
// A scanner stage decodes the key and pushes into a two-entry key queue; the
// number builder pulls from it and writes a two-entry result queue.
// A sample passes through the key queue and then the result queue before it
// reaches the result ports, where pop can take it.
// Throughput: one sample per cycle while full is low, set by the combinational
// scanner update and the combinational times-ten add in the number builder.
// When pop stays low, results fill the result queue, then the key queue,
// and full rises; nothing is dropped.
// Reset (i_rst_n low, synchronous): queues empty, scanner waits for a press,
// number and overflow cleared, key maps return to the default layout.
// Key maps are written through i_cfg_we / i_cfg_index / i_cfg_data by the
// user only while idle, not enforced by the block; other indexes are ignored.
//

module keypad_scan_number_entry
    import ksne_pkg::*;
#(
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [63:0]             i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [3:0]              i_column_sample,
    output logic                    empty,
    input  logic                    pop,
    output logic [3:0]              o_row_drive,
    output logic                    o_key_valid,
    output logic [7:0]              o_key_code,
    output logic [NUMBER_WIDTH-1:0] o_number_value,
    output logic                    o_number_done,
    output logic                    o_number_overflow
);

    localparam int unsigned RES_W = KEY_REC_W + NUMBER_WIDTH + 2;

    t_key_rec                w_front_rec;
    t_key_rec                w_key_rec;
    logic                    w_accept;
    logic                    w_key_empty;
    logic                    w_take;
    logic                    w_res_full;
    logic [NUMBER_WIDTH-1:0] w_value;
    logic                    w_done;
    logic                    w_ovf;
    logic [RES_W-1:0]        w_res_in;
    logic [RES_W-1:0]        w_res_out;

    assign w_accept = push & ~full;

    // scanner
    ksne_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (w_accept),
        .i_column_sample (i_column_sample),
        .o_rec           (w_front_rec)
    );

    // decoded keys waiting for the number builder
    ksne_fifo #(
        .WIDTH (KEY_REC_W)
    ) u_key_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_front_rec),
        .o_full  (full),
        .i_pop   (w_take),
        .o_data  (w_key_rec),
        .o_empty (w_key_empty)
    );

    // number builder
    ksne_back #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (w_key_rec),
        .i_rec_avail (~w_key_empty),
        .i_out_room  (~w_res_full),
        .o_take      (w_take),
        .o_value     (w_value),
        .o_done      (w_done),
        .o_overflow  (w_ovf)
    );

    assign w_res_in = {w_key_rec, w_value, w_done, w_ovf};

    // finished results
    ksne_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign {o_row_drive, o_key_valid, o_key_code, o_number_value,
            o_number_done, o_number_overflow} = w_res_out;

endmodule

// ===== hw/rtl/ksne_fifo.sv =====
// ksne_fifo: two-entry queue with simultaneous push and pop
`timescale 1ns / 1ps

module ksne_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // occupancy update
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/ksne_front.sv =====
// ksne_front: row scanner state machine and key map decode
`timescale 1ns / 1ps

module ksne_front
    import ksne_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    input  logic                   i_accept,
    input  logic [3:0]             i_column_sample,
    output t_key_rec               o_rec
);

    t_scan_phase r_phase;
    t_scan_phase n_phase;
    logic [1:0]  r_row;
    logic [1:0]  n_row;
    logic [63:0] r_keymap_low;
    logic [63:0] r_keymap_high;
    logic        w_pressed;
    logic [1:0]  w_col;
    logic [63:0] w_map_word;
    logic [7:0]  w_code;
    logic [1:0]  w_row_next;

    assign w_pressed  = (i_column_sample != COLS_RELEASED);
    assign w_row_next = r_row + 2'd1;

    // lowest numbered low column
    always_comb begin
        priority if (!i_column_sample[0]) begin
            w_col = 2'd0;
        end else if (!i_column_sample[1]) begin
            w_col = 2'd1;
        end else if (!i_column_sample[2]) begin
            w_col = 2'd2;
        end else if (!i_column_sample[3]) begin
            w_col = 2'd3;
        end else begin
            w_col = 2'd0;
        end
    end

    // key map byte for row and column
    assign w_map_word = r_row[1] ? r_keymap_high : r_keymap_low;
    assign w_code     = w_map_word[{r_row[0], w_col, 3'b000} +: 8];

    // next state
    always_comb begin
        n_phase = r_phase;
        n_row   = r_row;
        unique case (r_phase)
            PH_SCAN: begin
                if (w_pressed) begin
                    n_phase = PH_WAIT_RELEASE;
                end else if (r_row != ROW_LAST) begin
                    n_row = w_row_next;
                end else begin
                    n_phase = PH_WAIT_PRESS;
                    n_row   = 2'd0;
                end
            end
            PH_WAIT_RELEASE: begin
                if (!w_pressed) begin
                    n_phase = PH_WAIT_PRESS;
                end
            end
            default: begin
                n_phase = PH_WAIT_PRESS;
                if (w_pressed) begin
                    n_phase = PH_SCAN;
                    n_row   = 2'd0;
                end
            end
        endcase
    end

    // outputs for this tick
    always_comb begin
        o_rec = '{row_drive: DRIVE_ALL, key_valid: 1'b0, key_code: 8'h00};
        unique case (r_phase)
            PH_SCAN: begin
                if (w_pressed) begin
                    o_rec.key_valid = 1'b1;
                    o_rec.key_code  = w_code;
                end else if (r_row != ROW_LAST) begin
                    o_rec.row_drive = ~(4'b0001 << w_row_next);
                end
            end
            PH_WAIT_RELEASE: begin
                o_rec.row_drive = DRIVE_ALL;
            end
            default: begin
                if (w_pressed) begin
                    o_rec.row_drive = DRIVE_ROW0;
                end
            end
        endcase
    end

    // scanner state, advanced on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_PRESS;
            r_row   <= 2'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_row   <= n_row;
        end
    end

    // key map registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keymap_low  <= KEYMAP_LOW_RST;
            r_keymap_high <= KEYMAP_HIGH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_KEYMAP_LOW) begin
                r_keymap_low <= i_cfg_data;
            end
            if (i_cfg_index == REG_KEYMAP_HIGH) begin
                r_keymap_high <= i_cfg_data;
            end
        end
    end

endmodule

// ===== hw/rtl/ksne_back.sv =====
// ksne_back: decimal number accumulation with saturation
`timescale 1ns / 1ps

module ksne_back
    import ksne_pkg::*;
#(
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_key_rec                i_rec,
    input  logic                    i_rec_avail,
    input  logic                    i_out_room,
    output logic                    o_take,
    output logic [NUMBER_WIDTH-1:0] o_value,
    output logic                    o_done,
    output logic                    o_overflow
);

    localparam int unsigned PROD_W = NUMBER_WIDTH + 4;

    logic [NUMBER_WIDTH-1:0] r_accum;
    logic [NUMBER_WIDTH-1:0] n_accum;
    logic                    r_ovf;
    logic                    n_ovf;
    logic                    w_is_digit;
    logic [7:0]              w_digit_full;
    logic [PROD_W-1:0]       w_sum;
    logic                    w_sat;

    assign o_take = i_rec_avail & i_out_room;

    assign w_is_digit   = (i_rec.key_code >= CHAR_ZERO) && (i_rec.key_code <= CHAR_NINE);
    assign w_digit_full = i_rec.key_code - CHAR_ZERO;

    // accum * 10 + digit
    assign w_sum = {4'b0000, r_accum} * PROD_W'(DECIMAL_BASE)
                 + PROD_W'(w_digit_full[3:0]);
    assign w_sat = (w_sum[PROD_W-1:NUMBER_WIDTH] != 4'b0000);

    // result fields and next accumulator
    always_comb begin
        n_accum    = r_accum;
        n_ovf      = r_ovf;
        o_value    = r_accum;
        o_overflow = r_ovf;
        o_done     = 1'b0;
        if (i_rec.key_valid) begin
            if (w_is_digit) begin
                if (w_sat) begin
                    n_accum = '1;
                    n_ovf   = 1'b1;
                end else begin
                    n_accum = w_sum[NUMBER_WIDTH-1:0];
                end
                o_value    = n_accum;
                o_overflow = n_ovf;
            end else begin
                o_done  = 1'b1;
                n_accum = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    // number state, advanced per transfer out of the key queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_ovf   <= 1'b0;
        end else if (o_take) begin
            r_accum <= n_accum;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== hw/rtl/ksne_checker.sv =====
// ksne_checker: port-level assertions for the keypad scanner, bound to the top level
`timescale 1ns / 1ps

module ksne_checker #(
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    empty,
    input logic                    pop,
    input logic [3:0]              o_row_drive,
    input logic                    o_key_valid,
    input logic [7:0]              o_key_code,
    input logic [NUMBER_WIDTH-1:0] o_number_value,
    input logic                    o_number_done,
    input logic                    o_number_overflow
);

    // a waiting result stays until transferred
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result withdrawn before transfer");

    // a waiting result does not change until transferred
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> ($stable(o_key_code) && $stable(o_number_value)
                              && $stable(o_row_drive) && $stable(o_number_done)
                              && $stable(o_number_overflow)))
        else $error("result changed before transfer");

    // a number only ends on a decoded key
    a_done_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_number_done) |-> o_key_valid)
        else $error("number ended without a key");

    // no key code without a key, and all rows driven on a decode tick
    a_key_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_key_valid && o_row_drive == 4'h0)
                    || (!o_key_valid && o_key_code == 8'h00)))
        else $error("key fields inconsistent");

endmodule

bind keypad_scan_number_entry ksne_checker #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
) u_ksne_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .empty             (empty),
    .pop               (pop),
    .o_row_drive       (o_row_drive),
    .o_key_valid       (o_key_valid),
    .o_key_code        (o_key_code),
    .o_number_value    (o_number_value),
    .o_number_done     (o_number_done),
    .o_number_overflow (o_number_overflow)
);

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the keypad scanner and number entry block
`timescale 1ns / 1ps

module testbench;
    import ksne_pkg::*;

    localparam int unsigned ENTRY_W = 32;
    localparam int unsigned ITEMS_PER_PHASE = 230;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [63:0] KEYMAP_ALL_NINE = 64'h3939_3939_3939_3939;

    // one result as seen on the o_ ports
    typedef struct packed {
        logic [3:0]         row_drive;
        logic               key_valid;
        logic [7:0]         key_code;
        logic [ENTRY_W-1:0] number_value;
        logic               number_done;
        logic               number_overflow;
    } t_result;

    // one row of the directed script
    typedef struct packed {
        logic [3:0] cols;
        logic       typed;
        t_result    want;
    } t_script_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [63:0]            i_cfg_data;
    logic                   push;
    logic                   full;
    logic [3:0]             i_column_sample;
    logic                   empty;
    logic                   pop;
    logic [3:0]             o_row_drive;
    logic                   o_key_valid;
    logic [7:0]             o_key_code;
    logic [ENTRY_W-1:0]     o_number_value;
    logic                   o_number_done;
    logic                   o_number_overflow;

    // predictor state
    t_scan_phase        scan_state;
    logic [1:0]         scan_row;
    logic [ENTRY_W-1:0] entry_value;
    logic               entry_ovf;
    logic [63:0]        map_lo;
    logic [63:0]        map_hi;
    logic [3:0]         last_drive;

    // key press model
    logic [1:0] held_row;
    logic [1:0] held_col;
    logic [3:0] held_mask;
    int         hold_left;
    int         release_left;

    t_result due_results[$];
    int      fail_count;
    bit      gaps_on;

    // short walk through reset, digits, ending key, lost key and two columns
    t_script_row script [0:24] = '{
        {4'hF, 1'b1, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},  // idle after reset
        {4'h0, 1'b1, 4'hE, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},  // all columns low
        {4'h0, 1'b1, 4'h0, 1'b1, 8'h31, 32'd1,  1'b0, 1'b0},  // key 1
        {4'h0, 1'b1, 4'h0, 1'b0, 8'h00, 32'd1,  1'b0, 1'b0},  // still held
        {4'hF, 1'b1, 4'h0, 1'b0, 8'h00, 32'd1,  1'b0, 1'b0},  // released
        {4'hB, 1'b1, 4'hE, 1'b0, 8'h00, 32'd1,  1'b0, 1'b0},
        {4'hF, 1'b1, 4'hD, 1'b0, 8'h00, 32'd1,  1'b0, 1'b0},
        {4'hB, 1'b1, 4'h0, 1'b1, 8'h36, 32'd16, 1'b0, 1'b0},  // key 6
        {4'hF, 1'b1, 4'h0, 1'b0, 8'h00, 32'd16, 1'b0, 1'b0},
        {4'h7, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'hF, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'hF, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'hF, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'h7, 1'b1, 4'h0, 1'b1, 8'h3E, 32'd16, 1'b1, 1'b0},  // ending key on row 3
        {4'h7, 1'b1, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'hF, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'hD, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'hF, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'hF, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'hF, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'hF, 1'b1, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},  // key lost, back to idle
        {4'hF, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'h9, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},
        {4'h9, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0},  // two columns, lower wins
        {4'hF, 1'b0, 4'h0, 1'b0, 8'h00, 32'd0,  1'b0, 1'b0}
    };

    keypad_scan_number_entry #(
        .NUMBER_WIDTH(ENTRY_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_column_sample  (i_column_sample),
        .empty            (empty),
        .pop              (pop),
        .o_row_drive      (o_row_drive),
        .o_key_valid      (o_key_valid),
        .o_key_code       (o_key_code),
        .o_number_value   (o_number_value),
        .o_number_done    (o_number_done),
        .o_number_overflow(o_number_overflow)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    // key map byte for a row and column
    function automatic logic [7:0] map_byte(input logic [1:0] row, input logic [1:0] col);
        logic [3:0]  idx;
        logic [63:0] word;
        idx = {row, col};
        word = idx[3] ? map_hi : map_lo;
        return word[idx[2:0]*8 +: 8];
    endfunction

    // one scan tick: scanner step, then number update
    function automatic t_result scan_and_accumulate(input logic [3:0] cols);
        t_result    res;
        logic       pressed;
        logic [1:0] col;
        logic [63:0] grown;
        res = '0;
        pressed = (cols != COLS_RELEASED);
        col = 2'd0;
        for (int c = 3; c >= 0; c--)
            if (!cols[c]) col = c[1:0];
        case (scan_state)
            PH_SCAN: begin
                if (pressed) begin
                    res.key_code = map_byte(scan_row, col);
                    res.key_valid = 1'b1;
                    scan_state = PH_WAIT_RELEASE;
                end else if (scan_row != ROW_LAST) begin
                    scan_row = scan_row + 2'd1;
                    res.row_drive = ~(4'b0001 << scan_row);
                end else begin
                    scan_state = PH_WAIT_PRESS;
                    scan_row = 2'd0;
                end
            end
            PH_WAIT_RELEASE: begin
                if (!pressed) scan_state = PH_WAIT_PRESS;
            end
            default: begin
                scan_state = PH_WAIT_PRESS;
                res.row_drive = DRIVE_ALL;
                if (pressed) begin
                    scan_state = PH_SCAN;
                    scan_row = 2'd0;
                    res.row_drive = DRIVE_ROW0;
                end
            end
        endcase
        // number entry
        res.number_value = entry_value;
        res.number_overflow = entry_ovf;
        if (res.key_valid) begin
            if (res.key_code >= CHAR_ZERO && res.key_code <= CHAR_NINE) begin
                grown = {32'd0, entry_value} * 64'd10 + 64'(res.key_code - CHAR_ZERO);
                if (grown > {32'd0, {ENTRY_W{1'b1}}}) begin
                    grown = {32'd0, {ENTRY_W{1'b1}}};
                    entry_ovf = 1'b1;
                end
                entry_value = grown[ENTRY_W-1:0];
                res.number_value = entry_value;
                res.number_overflow = entry_ovf;
            end else begin
                res.number_done = 1'b1;
                entry_value = '0;
                entry_ovf = 1'b0;
            end
        end
        last_drive = res.row_drive;
        return res;
    endfunction

    // press model: holds a key for a while, then lets go, with some chatter
    function automatic logic [3:0] next_columns();
        logic [3:0] cols;
        logic [7:0] code;
        cols = COLS_RELEASED;
        if (hold_left == 0 && release_left == 0) begin
            held_row = 2'($urandom_range(0, 3));
            held_col = 2'($urandom_range(0, 3));
            // lean toward digit keys so numbers grow long
            for (int k = 0; k < 3; k++) begin
                code = map_byte(held_row, held_col);
                if (!(code >= CHAR_ZERO && code <= CHAR_NINE) && $urandom_range(0, 3) != 0) begin
                    held_row = 2'($urandom_range(0, 3));
                    held_col = 2'($urandom_range(0, 3));
                end
            end
            held_mask = 4'b0001 << held_col;
            if ($urandom_range(0, 6) == 0) held_mask[$urandom_range(0, 3)] = 1'b1;
            hold_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 9);
            release_left = $urandom_range(1, 4);
        end
        if (hold_left != 0) begin
            hold_left--;
            if (!last_drive[held_row]) cols = ~held_mask;
        end else begin
            release_left--;
        end
        if ($urandom_range(0, 9) == 0) cols = 4'($urandom_range(0, 15));
        return cols;
    endfunction

    // one column sample transfer; typed rows carry their own expectation
    task automatic push_sample(input logic [3:0] cols, input logic typed, input t_result want);
        t_result got;
        i_column_sample <= cols;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        got = scan_and_accumulate(cols);
        due_results.push_back(typed ? want : got);
    endtask

    // wait until idle, then load both key maps, optionally poking the spare indexes
    task automatic reload_keymaps(input logic [63:0] lo, input logic [63:0] hi,
                                  input bit poke_spare);
        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (poke_spare) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= REG_SPARE_2;
            i_cfg_data <= ~lo;
            @(posedge i_clk);
            i_cfg_index <= REG_SPARE_3;
            i_cfg_data <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_KEYMAP_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        map_lo = lo;
        i_cfg_index <= REG_KEYMAP_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        map_hi = hi;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random key activity, with sender gaps when gaps_on is set
    task automatic run_presses(input int count);
        for (int n = 0; n < count; n++) begin
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            push_sample(next_columns(), 1'b0, '0);
        end
    endtask

    // random map: about half digit codes, half any byte
    function automatic logic [63:0] mixed_keymap();
        logic [63:0] word;
        for (int b = 0; b < 8; b++)
            word[b*8 +: 8] = $urandom_range(0, 1) ? CHAR_ZERO + 8'($urandom_range(0, 9))
                                                   : 8'($urandom_range(0, 255));
        return word;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // result sink with random stall bursts when gaps_on is set
    initial begin
        pop <= 1'b1;
        @(posedge i_clk);
        forever begin
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
        end
    end

    // check every result transfer against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (due_results.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = due_results.pop_front();
                compare_field("row_drive", 32'(want.row_drive), 32'(o_row_drive));
                compare_field("key_valid", 32'(want.key_valid), 32'(o_key_valid));
                compare_field("key_code", 32'(want.key_code), 32'(o_key_code));
                compare_field("number_value", want.number_value, o_number_value);
                compare_field("number_done", 32'(want.number_done), 32'(o_number_done));
                compare_field("number_overflow", 32'(want.number_overflow),
                              32'(o_number_overflow));
            end
        end
    end

    // stimulus
    initial begin
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_column_sample <= COLS_RELEASED;
        i_cfg_we <= 1'b0;
        i_cfg_index <= REG_KEYMAP_LOW;
        i_cfg_data <= '0;
        fail_count = 0;
        gaps_on = 1'b1;
        scan_state = PH_WAIT_PRESS;
        scan_row = 2'd0;
        entry_value = '0;
        entry_ovf = 1'b0;
        map_lo = KEYMAP_LOW_RST;
        map_hi = KEYMAP_HIGH_RST;
        last_drive = DRIVE_ALL;
        hold_left = 0;
        release_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk on the default map
        foreach (script[n])
            push_sample(script[n].cols, script[n].typed, script[n].want);
        run_presses(ITEMS_PER_PHASE);

        // extreme maps: nothing is a digit
        reload_keymaps(64'h0, {64{1'b1}}, 1'b1);
        run_presses(ITEMS_PER_PHASE);

        // upper rows all nines, drives saturation; no gaps here
        reload_keymaps(KEYMAP_ALL_NINE, KEYMAP_HIGH_RST, 1'b0);
        gaps_on = 1'b0;
        run_presses(ITEMS_PER_PHASE);

        // random maps
        reload_keymaps(mixed_keymap(), mixed_keymap(), 1'b1);
        gaps_on = 1'b1;
        run_presses(ITEMS_PER_PHASE);

        // back to the default layout, no idling to the end
        reload_keymaps(KEYMAP_LOW_RST, KEYMAP_HIGH_RST, 1'b0);
        gaps_on = 1'b0;
        run_presses(ITEMS_PER_PHASE);

        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
